[rtl/core/s20_pkg.sv]
// Shared types, constants and round functions for the Salsa20 stream cipher core.
`default_nettype none
package s20_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;

  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  localparam int ROUND_COUNT_DEFAULT = 20;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_index_t CFG_KEY_LOW    = 3'd0;
  localparam cfg_index_t CFG_KEY_SECOND = 3'd1;
  localparam cfg_index_t CFG_KEY_THIRD  = 3'd2;
  localparam cfg_index_t CFG_KEY_HIGH   = 3'd3;
  localparam cfg_index_t CFG_NONCE      = 3'd4;
  localparam cfg_index_t CFG_START      = 3'd5;

  typedef struct packed {
    logic accept;
    logic restart;
    logic load;
    logic round_step;
    logic row;
    logic finish;
    logic emit;
    logic use_input;
  } s20_cmd_t;

  typedef struct packed {
    logic pos_last;
  } s20_stat_t;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic state_t transpose(input state_t w);
    state_t t;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        t[i*4+j] = w[j*4+i];
      end
    end
    return t;
  endfunction

  // Four quarter-rounds of one column pass; a row pass is this on the transposed state.
  function automatic state_t column_pass(input state_t w);
    state_t r;
    int a;
    int b;
    int c;
    int d;
    r = w;
    for (int q = 0; q < 4; q++) begin
      a = q * 5;
      b = (a + 4) % 16;
      c = (a + 8) % 16;
      d = (a + 12) % 16;
      r[b] = r[b] ^ rotl(r[a] + r[d], 7);
      r[c] = r[c] ^ rotl(r[b] + r[a], 9);
      r[d] = r[d] ^ rotl(r[c] + r[b], 13);
      r[a] = r[a] ^ rotl(r[d] + r[c], 18);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/salsa20_stream_cipher_core.sv]
// Top level of the Salsa20 stream cipher core.
// Each input word carries one byte and returns one byte XORed with the next
// Salsa20 keystream byte. A byte from an existing keystream block goes
// straight to the output register. A byte that needs a new block (the first
// after reset, the first of a message marked by message_start, and the first
// of each later 64-byte block) first has the state loaded, then ROUND_COUNT
// rounded up to even passes, one column or row pass of four quarter-rounds per
// cycle in the shared round unit, then the final addition and the byte select.
// The result sits in an output register; a new input can be taken in the cycle
// the result is taken, and the input stalls while a block is generated or while
// the output is stalled.
// Configuration writes are always ready and should be issued only while idle.
`default_nettype none
module salsa20_stream_cipher_core #(
  parameter int ROUND_COUNT = s20_pkg::ROUND_COUNT_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               message_start,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              result_byte,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire s20_pkg::cfg_index_t cfg_index,
  input  wire s20_pkg::cfg_data_t  cfg_data
);
  import s20_pkg::*;

  s20_cmd_t  cmd;
  s20_stat_t stat;

  assign cfg_ready = 1'b1;

  s20_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .message_start(message_start),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  s20_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_byte  (data_byte),
    .cmd        (cmd),
    .stat       (stat),
    .result_byte(result_byte)
  );

endmodule
`default_nettype wire

[rtl/core/s20_datapath.sv]
// Datapath: configuration, state words, keystream words, counters and output word.
`default_nettype none
module s20_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire s20_pkg::cfg_index_t cfg_index,
  input  wire s20_pkg::cfg_data_t  cfg_data,
  input  wire logic [7:0]         data_byte,
  input  wire s20_pkg::s20_cmd_t  cmd,
  output s20_pkg::s20_stat_t      stat,
  output logic [7:0]              result_byte
);
  import s20_pkg::*;

  logic [63:0] key_low_word;
  logic [63:0] key_second_word;
  logic [63:0] key_third_word;
  logic [63:0] key_high_word;
  logic [63:0] nonce_value;
  logic [63:0] start_counter;
  logic [63:0] block_counter;
  logic [5:0]  byte_position;
  logic [7:0]  data_hold;
  state_t      work;
  state_t      ks_block;
  state_t      init;
  state_t      round_in;
  state_t      round_out;
  word_t       ks_word;
  logic [7:0]  ks_byte;
  logic [7:0]  src_byte;

  always_comb begin
    init[0]  = SIGMA0;
    init[1]  = key_low_word[31:0];
    init[2]  = key_low_word[63:32];
    init[3]  = key_second_word[31:0];
    init[4]  = key_second_word[63:32];
    init[5]  = SIGMA1;
    init[6]  = nonce_value[31:0];
    init[7]  = nonce_value[63:32];
    init[8]  = block_counter[31:0];
    init[9]  = block_counter[63:32];
    init[10] = SIGMA2;
    init[11] = key_third_word[31:0];
    init[12] = key_third_word[63:32];
    init[13] = key_high_word[31:0];
    init[14] = key_high_word[63:32];
    init[15] = SIGMA3;
  end

  always_comb begin
    round_in  = cmd.row ? transpose(work) : work;
    round_out = cmd.row ? transpose(column_pass(round_in)) : column_pass(round_in);
  end

  assign ks_word  = ks_block[byte_position[5:2]];
  assign ks_byte  = 8'(ks_word >> {byte_position[1:0], 3'b000});
  assign src_byte = cmd.use_input ? data_byte : data_hold;
  assign stat.pos_last = &byte_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_word    <= '0;
      key_second_word <= '0;
      key_third_word  <= '0;
      key_high_word   <= '0;
      nonce_value     <= '0;
      start_counter   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_LOW:    key_low_word    <= cfg_data;
        CFG_KEY_SECOND: key_second_word <= cfg_data;
        CFG_KEY_THIRD:  key_third_word  <= cfg_data;
        CFG_KEY_HIGH:   key_high_word   <= cfg_data;
        CFG_NONCE:      nonce_value     <= cfg_data;
        CFG_START:      start_counter   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      byte_position <= '0;
    end else if (cmd.restart) begin
      block_counter <= start_counter;
      byte_position <= '0;
    end else if (cmd.emit) begin
      byte_position <= byte_position + 6'd1;
      if (stat.pos_last) begin
        block_counter <= block_counter + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_hold <= data_byte;
    end
    if (cmd.load) begin
      work <= init;
    end else if (cmd.round_step) begin
      work <= round_out;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) begin
        ks_block[i] <= work[i] + init[i];
      end
    end
    if (cmd.emit) begin
      result_byte <= src_byte ^ ks_byte;
    end
  end

endmodule
`default_nettype wire

[rtl/core/s20_ctrl.sv]
// Controller: handshakes, block generation sequence and round counter.
`default_nettype none
module s20_ctrl #(
  parameter int ROUND_COUNT = s20_pkg::ROUND_COUNT_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              message_start,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire s20_pkg::s20_stat_t stat,
  output s20_pkg::s20_cmd_t      cmd
);
  import s20_pkg::*;

  localparam int ROUND_STEPS = ((ROUND_COUNT + 1) / 2) * 2;
  localparam int RW = $clog2(ROUND_STEPS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [RW-1:0] round_cnt;
  logic [RW-1:0] round_cnt_next;
  logic          ks_ready;
  logic          ks_ready_next;
  logic          out_valid_next;
  logic          out_free;
  logic          accept;
  logic          need_block;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = !((state == ST_IDLE) && out_free);
  assign accept     = in_valid && !in_stall;
  assign need_block = message_start || !ks_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    round_cnt_next = round_cnt;
    ks_ready_next  = ks_ready;
    case (state)
      ST_IDLE: begin
        cmd.accept  = accept;
        cmd.restart = accept && message_start;
        if (accept) begin
          if (need_block) begin
            state_next = ST_LOAD;
          end else begin
            cmd.emit      = 1'b1;
            cmd.use_input = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd.load       = 1'b1;
        round_cnt_next = '0;
        state_next     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        cmd.row        = round_cnt[0];
        round_cnt_next = round_cnt + RW'(1);
        if (round_cnt == RW'(ROUND_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish    = 1'b1;
        ks_ready_next = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.restart) begin
      ks_ready_next = 1'b0;
    end
    if (cmd.emit && stat.pos_last) begin
      ks_ready_next = 1'b0;
    end
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
      ks_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      round_cnt <= round_cnt_next;
      ks_ready  <= ks_ready_next;
      out_valid <= out_valid_next;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("word written over a pending output");

  a_direct_needs_ks: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.use_input) |-> ks_ready)
    else $error("direct output without a keystream block");

  a_finish_sets_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> (ks_ready && (state == ST_EMIT)))
    else $error("block finish did not mark keystream ready");

  a_round_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round_cnt == RW'(ROUND_STEPS - 1)) |=> (state == ST_FINISH))
    else $error("round sequence ended at the wrong count");

endmodule
`default_nettype wire

[tb/tb_salsa20_stream_cipher_core.sv]
// Self-checking testbench for the Salsa20 stream cipher core: keystream prediction and byte check.
`timescale 1ns / 100ps
module tb_salsa20_stream_cipher_core;
  import s20_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int DOUBLE_ROUNDS  = (ROUND_COUNT_DEFAULT + 1) / 2;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_BYTES    = 123;
  localparam int PRESSURE_PHASE = 4;
  localparam int MAX_WAIT       = 18;
  localparam int TAIL_CYCLES    = 40;

  typedef struct {
    logic [7:0]  data;
    logic        start;
    int unsigned gap;
  } byte_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       message_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] result_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_KEY_LOW;
  cfg_data_t  cfg_data = '0;

  byte_req_t  pending_bytes[$];
  logic [7:0] predicted_bytes[$];

  logic [63:0] key_w0 = '0;
  logic [63:0] key_w1 = '0;
  logic [63:0] key_w2 = '0;
  logic [63:0] key_w3 = '0;
  logic [63:0] nonce_w = '0;
  logic [63:0] start_ctr = '0;
  state_t      ks_words = '0;
  logic [5:0]  ks_pos = '0;
  logic [63:0] ks_ctr = '0;
  logic        ks_valid = 1'b0;

  int unsigned tx_mode = 0;
  int unsigned rx_mode = 0;
  int unsigned tx_idle_cnt = 0;
  int unsigned rx_stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned blocks_made = 0;
  int unsigned settings_used = 0;

  salsa20_stream_cipher_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .message_start (message_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_byte   (result_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  function automatic state_t quarter_mix(input state_t w, input int a, input int b,
                                         input int c, input int d);
    w[b] = w[b] ^ rol32(w[a] + w[d], 7);
    w[c] = w[c] ^ rol32(w[b] + w[a], 9);
    w[d] = w[d] ^ rol32(w[c] + w[b], 13);
    w[a] = w[a] ^ rol32(w[d] + w[c], 18);
    return w;
  endfunction

  function automatic state_t salsa_block(input logic [63:0] ctr);
    state_t init;
    state_t w;
    init[0]  = SIGMA0;
    init[1]  = key_w0[31:0];
    init[2]  = key_w0[63:32];
    init[3]  = key_w1[31:0];
    init[4]  = key_w1[63:32];
    init[5]  = SIGMA1;
    init[6]  = nonce_w[31:0];
    init[7]  = nonce_w[63:32];
    init[8]  = ctr[31:0];
    init[9]  = ctr[63:32];
    init[10] = SIGMA2;
    init[11] = key_w2[31:0];
    init[12] = key_w2[63:32];
    init[13] = key_w3[31:0];
    init[14] = key_w3[63:32];
    init[15] = SIGMA3;
    w = init;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      w = quarter_mix(w, 0, 4, 8, 12);
      w = quarter_mix(w, 5, 9, 13, 1);
      w = quarter_mix(w, 10, 14, 2, 6);
      w = quarter_mix(w, 15, 3, 7, 11);
      w = quarter_mix(w, 0, 1, 2, 3);
      w = quarter_mix(w, 5, 6, 7, 4);
      w = quarter_mix(w, 10, 11, 8, 9);
      w = quarter_mix(w, 15, 12, 13, 14);
    end
    for (int i = 0; i < 16; i++) begin
      w[i] = w[i] + init[i];
    end
    return w;
  endfunction

  task automatic predict_cipher_byte(input logic [7:0] d, input logic st);
    logic [31:0] w;
    logic [7:0]  ks;
    if (st) begin
      ks_ctr   = start_ctr;
      ks_pos   = '0;
      ks_valid = 1'b0;
    end
    if (!ks_valid) begin
      ks_words = salsa_block(ks_ctr);
      ks_valid = 1'b1;
      blocks_made++;
    end
    w  = ks_words[ks_pos[5:2]];
    ks = w[ks_pos[1:0]*8 +: 8];
    predicted_bytes.push_back(d ^ ks);
    ks_pos = ks_pos + 6'd1;
    if (ks_pos == 6'd0) begin
      ks_ctr   = ks_ctr + 64'd1;
      ks_valid = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s: got %02h expected %02h", $time, what, got, want);
  endtask

  function automatic int unsigned draw_wait(input int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, MAX_WAIT);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
    endcase
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_reg();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // drive: predict on acceptance, then present the next queued word after its gap
  always @(posedge clk) begin
    byte_req_t nxt;
    if (rst) begin
      in_valid      <= 1'b0;
      message_start <= 1'b0;
      tx_idle_cnt   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_LOW:    key_w0    = cfg_data;
          CFG_KEY_SECOND: key_w1    = cfg_data;
          CFG_KEY_THIRD:  key_w2    = cfg_data;
          CFG_KEY_HIGH:   key_w3    = cfg_data;
          CFG_NONCE:      nonce_w   = cfg_data;
          CFG_START:      start_ctr = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_cipher_byte(data_byte, message_start);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && tx_idle_cnt >= pending_bytes[0].gap) begin
          nxt = pending_bytes.pop_front();
          in_valid      <= 1'b1;
          data_byte     <= nxt.data;
          message_start <= nxt.start;
          tx_idle_cnt   <= 0;
        end else begin
          in_valid <= 1'b0;
          if (pending_bytes.size() != 0) tx_idle_cnt <= tx_idle_cnt + 1;
        end
      end
    end
  end

  // check each accepted word against the oldest prediction, then draw the next stall
  always @(posedge clk) begin
    int unsigned d;
    logic [7:0]  want;
    if (rst) begin
      out_stall     <= 1'b0;
      rx_stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (predicted_bytes.size() == 0) begin
          report_mismatch("result_byte with nothing expected", result_byte, 8'h00);
        end else begin
          want = predicted_bytes.pop_front();
          if (result_byte !== want) report_mismatch("result_byte", result_byte, want);
        end
      end
      if (rx_stall_left != 0) begin
        rx_stall_left <= rx_stall_left - 1;
        out_stall     <= (rx_stall_left > 1);
      end else if (out_valid && !out_stall) begin
        d = draw_wait(rx_mode);
        rx_stall_left <= d;
        out_stall     <= (d != 0);
      end
    end
  end

  task automatic queue_byte(input logic [7:0] d, input logic st);
    byte_req_t r;
    r.data  = d;
    r.start = st;
    r.gap   = draw_wait(tx_mode);
    pending_bytes.push_back(r);
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || predicted_bytes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0]  edge_bytes[8];
    int unsigned sent;
    int unsigned len;
    bit          keep_block;
    bit          first_msg;
    edge_bytes = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h55, 8'haa, 8'h7f, 8'hfe};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // stream straight from reset, then restarts, both of them mid-block
    tx_mode = 1;
    rx_mode = 1;
    foreach (edge_bytes[i]) queue_byte(edge_bytes[i], 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h3c, 1'b0);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'h00, 1'b0);
    drain_all();

    // all-ones registers written mid-block: keep the current block, then restart
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_KEY_SECOND, '1);
    write_reg(CFG_KEY_THIRD, '1);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_NONCE, '1);
    write_reg(CFG_START, '1);
    settings_used++;
    @(negedge clk);
    tx_mode = 0;
    rx_mode = 0;
    for (int i = 0; i < 4; i++) queue_byte(edge_bytes[i], 1'b0);
    queue_byte(8'ha5, 1'b1);
    for (int i = 4; i < 8; i++) queue_byte(edge_bytes[i], 1'b0);
    drain_all();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_KEY_LOW, '0);
          write_reg(CFG_KEY_SECOND, '0);
          write_reg(CFG_KEY_THIRD, '0);
          write_reg(CFG_KEY_HIGH, '0);
          write_reg(CFG_NONCE, '0);
          write_reg(CFG_START, '0);
        end
        1: begin
          write_reg(CFG_KEY_LOW, {$urandom, $urandom});
          write_reg(CFG_KEY_SECOND, {$urandom, $urandom});
          write_reg(CFG_KEY_THIRD, {$urandom, $urandom});
          write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
          write_reg(CFG_NONCE, {$urandom, $urandom});
          write_reg(CFG_START, '1);
        end
        2: begin
          write_reg(CFG_NONCE, {$urandom, $urandom});
          write_reg(CFG_START, 64'h0000_0000_ffff_ffff);
        end
        3: write_reg(CFG_START, 64'hffff_ffff_ffff_ffff - $urandom_range(0, 2));
        default: begin
          if ($urandom_range(0, 1)) write_reg(CFG_KEY_LOW, rand_reg());
          if ($urandom_range(0, 1)) write_reg(CFG_KEY_SECOND, rand_reg());
          if ($urandom_range(0, 1)) write_reg(CFG_KEY_THIRD, rand_reg());
          if ($urandom_range(0, 1)) write_reg(CFG_KEY_HIGH, rand_reg());
          if ($urandom_range(0, 1)) write_reg(CFG_NONCE, rand_reg());
          write_reg(CFG_START, rand_reg());
        end
      endcase
      settings_used++;
      @(negedge clk);
      tx_mode    = $urandom_range(0, 2);
      rx_mode    = $urandom_range(0, 2);
      keep_block = ($urandom_range(0, 2) == 0);
      first_msg  = 1'b1;
      sent       = 0;
      while (sent < PHASE_BYTES) begin
        if (p < 4) len = $urandom_range(65, 200);
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(60, 200);
        else len = $urandom_range(1, 70);
        for (int k = 0; k < len && sent < PHASE_BYTES; k++) begin
          queue_byte(rand_data(), (k == 0) && !(first_msg && keep_block));
          sent++;
          if (p == PRESSURE_PHASE && sent == PHASE_BYTES / 2) drain_all();
        end
        first_msg = 1'b0;
      end
      drain_all();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    while (predicted_bytes.size() != 0) begin
      report_mismatch("result_byte never arrived", 8'h00, predicted_bytes.pop_front());
    end
    $display("Covered %0d bytes under %0d register settings, %0d keystream blocks.",
             bytes_sent, settings_used, blocks_made);
    $display("Compared %0d output bytes, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/core/s20_pkg.sv
rtl/core/s20_datapath.sv
rtl/core/s20_ctrl.sv
rtl/core/salsa20_stream_cipher_core.sv
tb/tb_salsa20_stream_cipher_core.sv
